FILE: design/nm245_pkg.sv
package nm245_pkg;

    // program pages and dividend of the serial reduction
    localparam int PAGE_W     = 9;
    localparam int PAGES      = 4;
    localparam int PAGE_IDX_W = 2;
    localparam int DIVIDEND_W = 8;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOUR_SCREEN = 1'd1;

    // register decode, on the address with bit 11 masked off
    localparam logic [15:0] ADDR_MASK        = 16'hF7FF;
    localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
    localparam logic [15:0] ADDR_MIRROR      = 16'hA000;
    localparam logic [15:0] ADDR_IRQ_COUNT   = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ENABLE  = 16'hE001;

    // bank select codes acted on by a bank data write
    localparam logic [7:0] BANK_SEL_OUTER = 8'd0;
    localparam logic [7:0] BANK_SEL_PRG_A = 8'd6;
    localparam logic [7:0] BANK_SEL_PRG_B = 8'd7;

    // fixed upper pages before the outer bank bit is merged in
    localparam logic [7:0] PAGE_FIXED_LOW  = 8'h3E;
    localparam logic [7:0] PAGE_FIXED_HIGH = 8'h3F;

    // mirroring requests
    localparam logic [1:0] MIRROR_NONE       = 2'd0;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;

    // classified operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
    localparam logic [OP_W-1:0] OP_BANK_SELECT = 4'd1;
    localparam logic [OP_W-1:0] OP_BANK_DATA   = 4'd2;
    localparam logic [OP_W-1:0] OP_MIRROR      = 4'd3;
    localparam logic [OP_W-1:0] OP_IRQ_COUNT   = 4'd4;
    localparam logic [OP_W-1:0] OP_IRQ_RELOAD  = 4'd5;
    localparam logic [OP_W-1:0] OP_IRQ_DISABLE = 4'd6;
    localparam logic [OP_W-1:0] OP_IRQ_ENABLE  = 4'd7;
    localparam logic [OP_W-1:0] OP_TICK        = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      data;
        logic            line_zero;
    } cmd_t;

endpackage

FILE: design/nm245_front.sv
module nm245_front #(
    parameter int unsigned VISIBLE_LAST_LINE = 239
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [15:0]        address,
    input  logic [7:0]         write_data,
    input  logic [8:0]         scanline,
    input  logic               rendering_on,
    output logic               push,
    output nm245_pkg::cmd_t    push_cmd,
    input  logic               queue_full
);

    logic            valid_reg;
    logic            valid_next;
    nm245_pkg::cmd_t cmd_reg;
    nm245_pkg::cmd_t cmd_next;
    logic            accept;
    logic [15:0]     masked;

    assign in_stall = valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !queue_full;
    assign push_cmd = cmd_reg;
    assign masked   = address & nm245_pkg::ADDR_MASK;

    // decode into one operation code
    always_comb
    begin
        cmd_next.data      = write_data;
        cmd_next.line_zero = (scanline == 9'd0);
        cmd_next.op        = nm245_pkg::OP_NOP;
        if (command)
        begin
            // ticks off the visible area or with rendering off do nothing
            if ((scanline <= 9'(VISIBLE_LAST_LINE)) && rendering_on)
            begin
                cmd_next.op = nm245_pkg::OP_TICK;
            end
        end
        else
        begin
            case (masked)
                nm245_pkg::ADDR_BANK_SELECT: cmd_next.op = nm245_pkg::OP_BANK_SELECT;
                nm245_pkg::ADDR_BANK_DATA:   cmd_next.op = nm245_pkg::OP_BANK_DATA;
                nm245_pkg::ADDR_MIRROR:      cmd_next.op = nm245_pkg::OP_MIRROR;
                nm245_pkg::ADDR_IRQ_COUNT:   cmd_next.op = nm245_pkg::OP_IRQ_COUNT;
                nm245_pkg::ADDR_IRQ_RELOAD:  cmd_next.op = nm245_pkg::OP_IRQ_RELOAD;
                nm245_pkg::ADDR_IRQ_DISABLE: cmd_next.op = nm245_pkg::OP_IRQ_DISABLE;
                nm245_pkg::ADDR_IRQ_ENABLE:  cmd_next.op = nm245_pkg::OP_IRQ_ENABLE;
                default:                     cmd_next.op = nm245_pkg::OP_NOP;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: design/nm245_queue.sv
module nm245_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nm245_pkg::cmd_t    push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output nm245_pkg::cmd_t    pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    nm245_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/nm245_mod.sv
module nm245_mod (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [nm245_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [nm245_pkg::PAGE_W-1:0]         divisor,
    output logic                                 done,
    output logic [nm245_pkg::PAGE_W-1:0]         remainder
);

    logic                                 busy_reg;
    logic                                 busy_next;
    logic                                 done_reg;
    logic                                 done_next;
    logic [nm245_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [nm245_pkg::DIV_CNT_W-1:0]      cnt_next;
    logic [nm245_pkg::DIVIDEND_W-1:0]     num_reg;
    logic [nm245_pkg::DIVIDEND_W-1:0]     num_next;
    logic [nm245_pkg::PAGE_W-1:0]         rem_reg;
    logic [nm245_pkg::PAGE_W-1:0]         rem_next;
    logic [nm245_pkg::PAGE_W:0]           trial;
    logic [nm245_pkg::PAGE_W:0]           divisor_ext;
    logic [nm245_pkg::PAGE_W-1:0]         rem_step;

    assign done      = done_reg;
    assign remainder = rem_reg;

    // restoring step, one dividend bit per cycle
    // a zero divisor subtracts nothing, so the value passes through
    assign divisor_ext = {1'b0, divisor};
    assign trial       = {rem_reg, num_reg[nm245_pkg::DIVIDEND_W-1]};
    assign rem_step    = (trial >= divisor_ext) ? nm245_pkg::PAGE_W'(trial - divisor_ext)
                                                : trial[nm245_pkg::PAGE_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            num_next = {num_reg[nm245_pkg::DIVIDEND_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == nm245_pkg::DIV_CNT_W'(nm245_pkg::DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

endmodule

FILE: design/nm245_back.sv
module nm245_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [nm245_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nm245_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  q_not_empty,
    input  nm245_pkg::cmd_t                       q_cmd,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [8:0]                            prg_page0,
    output logic [8:0]                            prg_page1,
    output logic [8:0]                            prg_page2,
    output logic [8:0]                            prg_page3,
    output logic [1:0]                            mirror_change,
    output logic                                  irq_line
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    localparam int PW = nm245_pkg::PAGE_W;
    localparam int IW = nm245_pkg::PAGE_IDX_W;

    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    logic [IW-1:0]  idx_reg;
    logic [IW-1:0]  idx_next;
    logic [IW-1:0]  last_idx;

    logic [PW-1:0]  page_count_reg;
    logic [PW-1:0]  page_count_next;
    logic           four_screen_reg;
    logic           four_screen_next;

    logic [7:0]     bank_select_reg;
    logic [7:0]     bank_select_next;
    logic [7:0]     prg_a_reg;
    logic [7:0]     prg_a_next;
    logic [7:0]     prg_b_reg;
    logic [7:0]     prg_b_next;
    logic           outer_reg;
    logic           outer_next;
    logic [PW-1:0]  page_reg [nm245_pkg::PAGES];
    logic [PW-1:0]  page_next [nm245_pkg::PAGES];
    logic [7:0]     irq_count_reg;
    logic [7:0]     irq_count_next;
    logic [7:0]     irq_reload_reg;
    logic [7:0]     irq_reload_next;
    logic           irq_enabled_reg;
    logic           irq_enabled_next;
    logic           irq_pending_reg;
    logic           irq_pending_next;

    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_free;
    logic           out_load;
    logic [1:0]     mirror_val;
    logic [PW-1:0]  out_page_reg [nm245_pkg::PAGES];
    logic [1:0]     out_mirror_reg;
    logic           out_irq_reg;

    logic           mod_start;
    logic [7:0]     mod_dividend;
    logic           mod_done;
    logic [PW-1:0]  mod_rem;
    logic [7:0]     outer_bits;
    logic [7:0]     count_pre;

    nm245_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (page_count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign prg_page0 = out_page_reg[0];
    assign prg_page1 = out_page_reg[1];
    assign prg_page2 = out_page_reg[2];
    assign prg_page3 = out_page_reg[3];
    assign mirror_change = out_mirror_reg;
    assign irq_line  = out_irq_reg;

    assign outer_bits = {1'b0, outer_reg, 6'd0};
    assign last_idx   = (bank_select_reg == nm245_pkg::BANK_SEL_OUTER) ? IW'(3) : IW'(1);

    always_comb
    begin
        case (idx_reg)
            IW'(0):  mod_dividend = prg_a_reg | outer_bits;
            IW'(1):  mod_dividend = prg_b_reg | outer_bits;
            IW'(2):  mod_dividend = nm245_pkg::PAGE_FIXED_LOW | outer_bits;
            default: mod_dividend = nm245_pkg::PAGE_FIXED_HIGH | outer_bits;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        page_count_next  = page_count_reg;
        four_screen_next = four_screen_reg;
        bank_select_next = bank_select_reg;
        prg_a_next       = prg_a_reg;
        prg_b_next       = prg_b_reg;
        outer_next       = outer_reg;
        page_next        = page_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        irq_enabled_next = irq_enabled_reg;
        irq_pending_next = irq_pending_reg;
        q_pop            = 1'b0;
        out_load         = 1'b0;
        mirror_val       = nm245_pkg::MIRROR_NONE;
        mod_start        = 1'b0;
        count_pre        = irq_count_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                nm245_pkg::REG_PAGE_COUNT:
                begin
                    page_count_next = cfg_data;
                    page_next[0]    = PW'(0);
                    page_next[1]    = PW'(1);
                    page_next[2]    = cfg_data - PW'(2);
                    page_next[3]    = cfg_data - PW'(1);
                end
                nm245_pkg::REG_FOUR_SCREEN:
                begin
                    four_screen_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty && out_free)
                begin
                    q_pop    = 1'b1;
                    out_load = 1'b1;
                    case (q_cmd.op)
                        nm245_pkg::OP_BANK_SELECT:
                        begin
                            bank_select_next = q_cmd.data;
                        end
                        nm245_pkg::OP_BANK_DATA:
                        begin
                            out_load = 1'b0;
                            if (bank_select_reg == nm245_pkg::BANK_SEL_OUTER)
                            begin
                                outer_next = q_cmd.data[1];
                            end
                            else if (bank_select_reg == nm245_pkg::BANK_SEL_PRG_A)
                            begin
                                prg_a_next = q_cmd.data;
                            end
                            else if (bank_select_reg == nm245_pkg::BANK_SEL_PRG_B)
                            begin
                                prg_b_next = q_cmd.data;
                            end
                            idx_next   = '0;
                            state_next = ST_START;
                        end
                        nm245_pkg::OP_MIRROR:
                        begin
                            if (!four_screen_reg)
                            begin
                                mirror_val = q_cmd.data[0] ? nm245_pkg::MIRROR_HORIZONTAL
                                                           : nm245_pkg::MIRROR_VERTICAL;
                            end
                        end
                        nm245_pkg::OP_IRQ_COUNT:
                        begin
                            irq_count_next   = q_cmd.data;
                            irq_pending_next = 1'b0;
                        end
                        nm245_pkg::OP_IRQ_RELOAD:
                        begin
                            irq_reload_next  = q_cmd.data;
                            irq_pending_next = 1'b0;
                        end
                        nm245_pkg::OP_IRQ_DISABLE:
                        begin
                            irq_enabled_next = 1'b0;
                            irq_pending_next = 1'b0;
                        end
                        nm245_pkg::OP_IRQ_ENABLE:
                        begin
                            irq_enabled_next = 1'b1;
                            irq_pending_next = 1'b0;
                        end
                        nm245_pkg::OP_TICK:
                        begin
                            if (irq_enabled_reg && !irq_pending_reg)
                            begin
                                // line zero takes an extra decrement first
                                if (q_cmd.line_zero && (irq_count_reg != 8'd0))
                                begin
                                    count_pre = irq_count_reg - 8'd1;
                                end
                                if (count_pre == 8'd0)
                                begin
                                    irq_pending_next = 1'b1;
                                    irq_count_next   = irq_reload_reg;
                                end
                                else
                                begin
                                    irq_count_next = count_pre - 8'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_START:
            begin
                mod_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mod_done)
                begin
                    page_next[idx_reg] = mod_rem;
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            page_count_reg  <= PW'(2);
            four_screen_reg <= 1'b0;
            bank_select_reg <= 8'd0;
            prg_a_reg       <= 8'd0;
            prg_b_reg       <= 8'd1;
            outer_reg       <= 1'b0;
            page_reg[0]     <= PW'(0);
            page_reg[1]     <= PW'(1);
            page_reg[2]     <= PW'(0);
            page_reg[3]     <= PW'(1);
            irq_count_reg   <= 8'd0;
            irq_reload_reg  <= 8'd0;
            irq_enabled_reg <= 1'b0;
            irq_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            page_count_reg  <= page_count_next;
            four_screen_reg <= four_screen_next;
            bank_select_reg <= bank_select_next;
            prg_a_reg       <= prg_a_next;
            prg_b_reg       <= prg_b_next;
            outer_reg       <= outer_next;
            page_reg        <= page_next;
            irq_count_reg   <= irq_count_next;
            irq_reload_reg  <= irq_reload_next;
            irq_enabled_reg <= irq_enabled_next;
            irq_pending_reg <= irq_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_page_reg   <= page_next;
            out_mirror_reg <= mirror_val;
            out_irq_reg    <= irq_pending_next;
        end
    end

endmodule

FILE: design/nes_mapper245_bank_irq.sv
// program banking and scanline irq unit of a mapper 245 cartridge
// input channel: in_valid / in_stall, one transaction per cpu register write
//   (command 0) or per scanline tick (command 1)
// output channel: out_valid / out_stall, exactly one result transaction per input,
//   in order: the four 8 kb page numbers, a mirroring request and the irq line
// config port: cfg_write with cfg_index 0 (page count) or 1 (four screen); the user
//   must write it only while the block is idle (not enforced by it); a page
//   count write reloads the pages; most results are registered in the front
//   register, the queue and the back output register
// a bank data write (0x8001) reduces page numbers modulo the page count in one
//   shared bit-serial unit, one page after another: 2 pages normally, 4 when
//   bank select is 0
// throughput: one transaction per cycle for simple writes and ticks unless the
//   receiver stalls; the serial modulo unit sets the rate of bank data writes
// reset: state cleared but bank b register 1, page count 2, pages 0,1,0,1
// when the receiver stalls the result holds in the output register, the back
//   end stops, the queue fills, and in_stall rises once the front is full too
module nes_mapper245_bank_irq #(
    parameter int unsigned VISIBLE_LAST_LINE = 239,
    parameter int unsigned QUEUE_DEPTH       = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_write,
    input  logic [nm245_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nm245_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input transactions
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [15:0]                           address,
    input  logic [7:0]                            write_data,
    input  logic [8:0]                            scanline,
    input  logic                                  rendering_on,
    // result transactions
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [8:0]                            prg_page0,
    output logic [8:0]                            prg_page1,
    output logic [8:0]                            prg_page2,
    output logic [8:0]                            prg_page3,
    output logic [1:0]                            mirror_change,
    output logic                                  irq_line
);

    logic            push;
    nm245_pkg::cmd_t push_cmd;
    logic            queue_full;
    logic            pop;
    logic            queue_not_empty;
    nm245_pkg::cmd_t pop_cmd;

    // front: decode and register one transaction
    nm245_front #(
        .VISIBLE_LAST_LINE (VISIBLE_LAST_LINE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .write_data   (write_data),
        .scanline     (scanline),
        .rendering_on (rendering_on),
        .push         (push),
        .push_cmd     (push_cmd),
        .queue_full   (queue_full)
    );

    // short queue of decoded operations between front and back
    nm245_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_cmd   (pop_cmd)
    );

    // back: mapper state, serial page reduction and the output register
    nm245_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_not_empty   (queue_not_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .prg_page0     (prg_page0),
        .prg_page1     (prg_page1),
        .prg_page2     (prg_page2),
        .prg_page3     (prg_page3),
        .mirror_change (mirror_change),
        .irq_line      (irq_line)
    );

endmodule
